// File: sv/dtv_pkg.sv
// ----------------------------------------------------------------------------
// dtv_pkg
// Shared types and codes for the decimal token validator.
// ----------------------------------------------------------------------------
package dtv_pkg;

  // action codes carried in tuser
  localparam logic [1:0] ACT_CHAR  = 2'd0;
  localparam logic [1:0] ACT_END   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_SYNTAX = 3'd1;
  localparam logic [2:0] ST_RANGE = 3'd2;
  localparam logic [2:0] ST_DUP   = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  // magnitude saturation point, 2^31
  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;

  // probe word that walks down the cell chain
  typedef struct packed {
    logic        valid;
    logic        hit;
    logic [31:0] value;
  } probe_t;

  // parser verdict for the token collected so far
  typedef struct packed {
    logic        syntax_bad;
    logic        out_of_range;
    logic [31:0] value;
  } parse_t;

endpackage

// File: sv/dtv_parse.sv
// ----------------------------------------------------------------------------
// dtv_parse
// Character-at-a-time token parser with saturating decimal magnitude.
// ----------------------------------------------------------------------------
module dtv_parse
  import dtv_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         char_en,   // one character this cycle
  input  logic [7:0]   char_byte,
  input  logic         restart,   // token end: back to leading blanks
  output parse_t       verdict
);

  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_SIGN  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  logic [1:0]  phase, phase_next;
  logic        neg, neg_next;
  logic [31:0] mag, mag_next;
  logic        ovf, ovf_next;
  logic        bad, bad_next;

  logic        is_digit;
  logic        is_blank;
  logic [3:0]  digit;
  logic [35:0] prod;

  assign is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
  assign is_blank = (char_byte == CH_SPACE) ||
                    ((char_byte >= CH_TAB) && (char_byte <= CH_CR));
  assign digit    = 4'(char_byte - CH_ZERO);
  // mag * 10 + digit
  assign prod     = ({4'd0, mag} << 3) + ({4'd0, mag} << 1) + 36'(digit);

  // next-state for one character
  always_comb begin
    phase_next = phase;
    neg_next   = neg;
    mag_next   = mag;
    ovf_next   = ovf;
    bad_next   = bad;
    if (char_en && !bad) begin
      if (is_digit) begin
        phase_next = PH_DIGIT;
        if (!ovf) begin
          if (prod > 36'(MAG_LIMIT)) begin
            ovf_next = 1'b1;
            mag_next = MAG_LIMIT;
          end else begin
            mag_next = prod[31:0];
          end
        end
      end else if (phase == PH_LEAD && is_blank) begin
        phase_next = phase;
      end else if (phase == PH_LEAD &&
                   (char_byte == CH_PLUS || char_byte == CH_MINUS)) begin
        neg_next   = (char_byte == CH_MINUS);
        phase_next = PH_SIGN;
      end else begin
        bad_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      phase <= PH_LEAD;
      neg   <= 1'b0;
      mag   <= '0;
      ovf   <= 1'b0;
      bad   <= 1'b0;
    end else begin
      phase <= phase_next;
      neg   <= neg_next;
      mag   <= mag_next;
      ovf   <= ovf_next;
      bad   <= bad_next;
    end
  end

  // verdict on the token as it stands
  assign verdict.syntax_bad   = bad || (phase != PH_DIGIT);
  assign verdict.out_of_range = ovf || (!neg && mag[31]);
  assign verdict.value        = neg ? (32'd0 - mag) : mag;

endmodule

// File: sv/dtv_cell.sv
// ----------------------------------------------------------------------------
// dtv_cell
// One stored-set entry; compares the passing probe and hands it on.
// ----------------------------------------------------------------------------
module dtv_cell
  import dtv_pkg::*;
#(
  parameter int CNT_W = 10,
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] count,    // entries below count are live
  input  logic             wr_en,
  input  logic [CNT_W-1:0] wr_addr,
  input  logic [31:0]      wr_data,
  input  probe_t           probe_in,
  output probe_t           probe_out
);

  logic [31:0] stored;
  logic        live;

  assign live = CNT_W'(INDEX) < count;

  // entry write
  always_ff @(posedge clk) begin
    if (wr_en && wr_addr == CNT_W'(INDEX)) begin
      stored <= wr_data;
    end
  end

  // probe stage; only the valid bit needs a reset
  always_ff @(posedge clk) begin
    probe_out.value <= probe_in.value;
    probe_out.hit   <= probe_in.hit || (live && probe_in.value == stored);
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_in.valid;
    end
  end

endmodule

// File: sv/decimal_token_validator_with_dedup_core.sv
// ----------------------------------------------------------------------------
// decimal_token_validator_with_dedup_core
// Decimal token parser with int32 range check and duplicate-free value set.
// ----------------------------------------------------------------------------
// Character, clear and ignored words: accepted one per cycle while s_tready is high.
// End-of-token word: s_tready drops until its result is loaded. A well-formed
// token walks the probe down the chain of SET_DEPTH cells, one cell per cycle,
// and its result is loaded once the probe leaves the last cell; a bad or
// out-of-range token skips the search and its result is loaded directly.
// A stalled result stalls the input.
// Synchronous active-high reset empties the set and restarts the parser.
// ----------------------------------------------------------------------------
module decimal_token_validator_with_dedup_core
  import dtv_pkg::*;
#(
  parameter int SET_DEPTH = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_byte
  input  logic [1:0]  s_tuser,   // [1:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // [2:0] status, [34:3] value, [44:35] stored_count
);

  localparam int CNT_W = $clog2(SET_DEPTH + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DONE   = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] count;
  logic             accept;
  logic             end_tok;
  logic             load;
  logic             keep;
  logic [2:0]       pend_status;
  logic [31:0]      cand;
  logic             dup;
  logic [2:0]       fin_status;
  logic             launch;
  parse_t           verdict;
  probe_t           chain [SET_DEPTH+1];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign end_tok  = accept && s_tuser == ACT_END;

  // parser
  dtv_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .char_en   (accept && s_tuser == ACT_CHAR),
    .char_byte (s_tdata),
    .restart   (end_tok),
    .verdict   (verdict)
  );

  // final status once the search verdict is in
  always_comb begin
    fin_status = pend_status;
    if (pend_status == ST_OK) begin
      if (dup) begin
        fin_status = ST_DUP;
      end else if (count >= CNT_W'(SET_DEPTH)) begin
        fin_status = ST_FULL;
      end
    end
  end

  assign load = (state == S_DONE) && (!m_tvalid || m_tready);
  assign keep = load && fin_status == ST_OK;

  // cell chain; the probe carries the candidate value
  assign chain[0] = '{valid: launch, hit: 1'b0, value: cand};

  for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cell
    dtv_cell #(
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .count     (count),
      .wr_en     (keep),
      .wr_addr   (count),
      .wr_data   (cand),
      .probe_in  (chain[i]),
      .probe_out (chain[i+1])
    );
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      launch   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      launch <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && s_tuser == ACT_CLEAR) begin
            count <= '0;
          end
          if (end_tok) begin
            if (verdict.syntax_bad || verdict.out_of_range) begin
              state <= S_DONE;
            end else begin
              launch <= 1'b1;
              state  <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (chain[SET_DEPTH].valid) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            state <= S_IDLE;
            if (keep) begin
              count <= count + CNT_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // token payload and search result
  always_ff @(posedge clk) begin
    if (end_tok) begin
      cand <= verdict.value;
      dup  <= 1'b0;
      if (verdict.syntax_bad) begin
        pend_status <= ST_SYNTAX;
      end else if (verdict.out_of_range) begin
        pend_status <= ST_RANGE;
      end else begin
        pend_status <= ST_OK;
      end
    end else if (state == S_SEARCH && chain[SET_DEPTH].valid) begin
      dup <= chain[SET_DEPTH].hit;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata[2:0]   <= fin_status;
      m_tdata[34:3]  <= (fin_status == ST_OK) ? cand : 32'd0;
      m_tdata[44:35] <= keep ? 10'(count + CNT_W'(1)) : 10'(count);
      m_tdata[47:45] <= 3'd0;
    end
  end

endmodule

// File: sv/dtv_checker.sv
// ----------------------------------------------------------------------------
// dtv_checker
// Port-level checks on the validator's result stream.
// ----------------------------------------------------------------------------
module dtv_checker
  import dtv_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed under stall");

  // status code is one of the defined ones
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= ST_FULL)
    else $error("undefined status code");

  // rejected tokens carry a zero value
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != ST_OK |-> m_tdata[34:3] == 32'd0)
    else $error("nonzero value on rejected token");

  // no result right after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind decimal_token_validator_with_dedup_core dtv_checker u_dtv_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
